@@ rtl/bns_pkg.sv @@
// ----------------------------------------------------------------------------
// bns_pkg
// Shared types and constants for the buzzer note sequencer.
// ----------------------------------------------------------------------------
package bns_pkg;

  localparam int NOTE_SLOTS = 6;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int CLK_W      = 32;
  localparam int TICK_W     = 16;
  localparam int FREQ_W     = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_FIRST = 3'd1;

  localparam logic [CLK_W-1:0]      CLOCK_HZ_RST = 32'd48000000;
  localparam logic [CFG_DATA_W-1:0] NOTE0_RST    = 48'd1589138098448;
  localparam logic [CFG_DATA_W-1:0] NOTE1_RST    = 48'd1589138229520;
  localparam logic [CFG_DATA_W-1:0] NOTE2_RST    = 48'd12884905822080;
  localparam logic [CFG_DATA_W-1:0] NOTE_ZERO    = 48'd0;

  localparam logic [CLK_W-1:0] PERIOD_SAT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  // one note table word, frequency in the low bits
  typedef struct packed {
    logic [TICK_W-1:0] len_ticks;
    logic [TICK_W-1:0] sound_ticks;
    logic [FREQ_W-1:0] freq;
  } note_t;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [CLK_W-1:0] dividend;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/bns_div.sv @@
// ----------------------------------------------------------------------------
// bns_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bns_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bns_pkg::div_req_t req,
  output bns_pkg::div_rsp_t rsp
);
  import bns_pkg::*;

  logic [FREQ_W-1:0]  rem_r, rem_nxt;
  logic [CLK_W-1:0]   quo_r, quo_nxt;
  logic [FREQ_W-1:0]  dvs_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [FREQ_W:0]    trial;
  logic [FREQ_W+1:0]  diff;
  logic               ge;

  // shift next dividend bit into the partial remainder, trial subtract
  always_comb begin
    trial   = {rem_r, quo_r[CLK_W-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_r};
    ge      = ~diff[FREQ_W+1];
    rem_nxt = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
    quo_nxt = {quo_r[CLK_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(CLK_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ rtl/bns_regs.sv @@
// ----------------------------------------------------------------------------
// bns_regs
// Configuration registers: tone clock and the note table, one read port.
// ----------------------------------------------------------------------------
module bns_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [bns_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [bns_pkg::CFG_DATA_W-1:0]      wr_data,
  input  logic [bns_pkg::SLOT_W-1:0]          rd_slot,
  output bns_pkg::note_t                      rd_note,
  output logic [bns_pkg::CLK_W-1:0]           clock_hz
);
  import bns_pkg::*;

  logic [CLK_W-1:0]      clock_hz_r;
  logic [CFG_DATA_W-1:0] note_r [NOTE_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_HZ_RST;
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        case (i)
          0:       note_r[i] <= NOTE0_RST;
          1:       note_r[i] <= NOTE1_RST;
          2:       note_r[i] <= NOTE2_RST;
          default: note_r[i] <= NOTE_ZERO;
        endcase
      end
    end else if (wr_en) begin
      if (wr_index == REG_CLOCK_HZ) begin
        clock_hz_r <= wr_data[CLK_W-1:0];
      end
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        if (wr_index == REG_NOTE_FIRST + CFG_IDX_W'(i)) begin
          note_r[i] <= wr_data;
        end
      end
    end
  end

  // slots past the table read as an empty note
  assign rd_note  = (rd_slot < SLOT_W'(NOTE_SLOTS)) ? note_t'(note_r[rd_slot]) : note_t'('0);
  assign clock_hz = clock_hz_r;

endmodule

@@ rtl/buzzer_note_sequencer.sv @@
// ----------------------------------------------------------------------------
// buzzer_note_sequencer
// Plays a run of notes from a six-slot table; one status result per item.
// ----------------------------------------------------------------------------
// Flow: IDLE -> PUSH when no tone period is loaded (stop, bad start, unused
//   opcode, tick that does not move to a new note); IDLE -> LOAD -> PUSH when a
//   zero frequency saturates the period; IDLE -> LOAD -> DIV -> PUSH when a period
//   is divided out by the 32-step bit-serial divider (one quotient bit per cycle).
// Throughput: one item at a time; next item taken once the result is queued.
// Reset: rst_n synchronous, active low; clears sequencer state and restores
//   the default tone clock and note table.
// ----------------------------------------------------------------------------
module buzzer_note_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bns_pkg::IN_DATA_W-1:0]       in_tdata,   // opcode[1:0], first_note[4:2],
                                                          // note_total[7:5]
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bns_pkg::OUT_DATA_W-1:0]      out_tdata,  // buzzer_enable[0], tone_running[1],
                                                          // tone_period[33:2],
                                                          // tone_compare[64:34], playing[65],
                                                          // note_position[68:66], zero pad
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bns_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bns_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bns_pkg::*;

  // Sequencer states. LOAD fetches the new note's frequency, DIV waits on
  // the period divider, PUSH hands the status to the output register.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;

  // architectural state
  logic                active_r, active_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   end_r, end_nxt;
  logic                buzz_r, buzz_nxt;
  logic                tone_r, tone_nxt;
  logic [CLK_W-1:0]    period_r, period_nxt;

  // output register
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  // decoded input transaction
  op_t                 op;
  logic [SLOT_W-1:0]   first_note;
  logic [SLOT_W-1:0]   note_total;
  logic                in_acc;
  logic                push;

  // helpers
  note_t               cur_note;
  logic [CLK_W-1:0]    clock_hz;
  logic [TICK_W-1:0]   cnt;
  logic [SLOT_W:0]     end_sum;
  logic [SLOT_W-1:0]   next_slot;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign op         = op_t'(in_tdata[1:0]);
  assign first_note = in_tdata[4:2];
  assign note_total = in_tdata[7:5];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign push       = (state_r == S_PUSH) && (!out_valid_r || out_tready);

  bns_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .rd_slot  (slot_r),
    .rd_note  (cur_note),
    .clock_hz (clock_hz)
  );

  bns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Divider kicks off in LOAD with the note now in slot_r; a zero frequency
  // skips it and saturates the period.
  assign div_req.start    = (state_r == S_LOAD) && (cur_note.freq != '0);
  assign div_req.dividend = clock_hz;
  assign div_req.divisor  = cur_note.freq;

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    tick_nxt   = tick_r;
    slot_nxt   = slot_r;
    end_nxt    = end_r;
    buzz_nxt   = buzz_r;
    tone_nxt   = tone_r;
    period_nxt = period_r;
    cnt        = tick_r + TICK_W'(1);
    end_sum    = {1'b0, first_note} + {1'b0, note_total};
    next_slot  = slot_r + SLOT_W'(1);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PUSH;
          case (op)
            OP_START: begin
              if (first_note >= SLOT_W'(NOTE_SLOTS) || note_total == '0) begin
                // bad start: run ends at once, period kept
                active_nxt = 1'b0;
                slot_nxt   = '0;
                tick_nxt   = '0;
                buzz_nxt   = 1'b0;
                tone_nxt   = 1'b0;
              end else begin
                if (end_sum > (SLOT_W+1)'(NOTE_SLOTS)) begin
                  end_nxt = SLOT_W'(NOTE_SLOTS);
                end else begin
                  end_nxt = end_sum[SLOT_W-1:0];
                end
                slot_nxt   = first_note;
                tick_nxt   = '0;
                active_nxt = 1'b1;
                buzz_nxt   = 1'b1;
                tone_nxt   = 1'b1;
                state_nxt  = S_LOAD;
              end
            end
            OP_STOP: begin
              buzz_nxt   = 1'b0;
              tone_nxt   = 1'b0;
              active_nxt = 1'b0;
            end
            OP_TICK: begin
              if (active_r) begin
                tick_nxt = cnt;
                if (cnt >= cur_note.sound_ticks) begin
                  buzz_nxt = 1'b0;
                end
                if (cnt >= cur_note.len_ticks) begin
                  tick_nxt = '0;
                  if (next_slot >= end_r || next_slot >= SLOT_W'(NOTE_SLOTS)) begin
                    active_nxt = 1'b0;
                    slot_nxt   = '0;
                    buzz_nxt   = 1'b0;
                    tone_nxt   = 1'b0;
                  end else begin
                    slot_nxt  = next_slot;
                    buzz_nxt  = 1'b1;
                    tone_nxt  = 1'b1;
                    state_nxt = S_LOAD;
                  end
                end
              end
            end
            default: begin
              // unused opcode: report present state
            end
          endcase
        end
      end
      S_LOAD: begin
        if (cur_note.freq == '0) begin
          period_nxt = PERIOD_SAT;
          state_nxt  = S_PUSH;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          period_nxt = div_rsp.quotient;
          state_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      tick_r      <= '0;
      slot_r      <= '0;
      end_r       <= '0;
      buzz_r      <= 1'b0;
      tone_r      <= 1'b0;
      period_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      tick_r   <= tick_nxt;
      slot_r   <= slot_nxt;
      end_r    <= end_nxt;
      buzz_r   <= buzz_nxt;
      tone_r   <= tone_nxt;
      period_r <= period_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, captured as the transaction is queued
  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= {3'b000, slot_r, active_r, period_r[CLK_W-1:1], period_r,
                     tone_r, buzz_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_slot_in_run : assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (slot_r < end_r) && (end_r <= SLOT_W'(NOTE_SLOTS)))
    else $error("current slot outside the active run");

  a_acc_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start processing");

  a_push_gives_valid : assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_tvalid)
    else $error("queued result not presented");

endmodule
